// ===== hw/rtl/cbd_pkg.sv =====
// Shared constants and types for the circular buffer deque.
// Used by the controller, the datapath and the top level; depends on nothing.
package cbd_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int FUNC_W = 3;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [WORD_W-1:0] NEG_ONE   = '1;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic clear;
   } cbd_cmd_type;

endpackage

// ===== hw/rtl/circular_buffer_deque.sv =====
// Circular buffer deque: push or pop signed words at either end of a ring store.
// A request accepted in idle steps through the execute, fetch and response states
// and has its result strobed on rsp_valid for one cycle; a new request is taken
// only back in idle, after the memory read that follows the pointer update.
// Synchronous reset empties the deque and sets the capacity to 16; the store
// itself is not cleared. The receiver cannot stall results.
module circular_buffer_deque (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cbd_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [cbd_pkg::WORD_W-1:0] req_push_value,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_pop_value,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_front_value,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_rear_value,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbd_pkg::CAP_W-1:0]         csr_data
);

   cbd_pkg::cbd_cmd_type cmd;

   cbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   cbd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .csr_data        (csr_data),
      .rsp_ok          (rsp_ok),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

// ===== hw/rtl/cbd_ctrl.sv =====
// Request sequencer of the circular buffer deque.
// Depends on cbd_pkg for the command struct.
module cbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 csr_valid,
   output logic                 busy,
   output logic                 csr_ready,
   output logic                 rsp_valid,
   output cbd_pkg::cbd_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_RESP  = 4'b1000
   } cbd_state_type;

   cbd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = (state_ff == ST_RESP);

   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.clear = csr_valid && csr_ready;

   // An accepted request produces its strobe once it has passed the execute and fetch states.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response strobe missing after request");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("controller not idle after response");

   a_no_clear_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.exec && !cmd.load)
      else $error("capacity write overlaps a request");

endmodule

// ===== hw/rtl/cbd_datapath.sv =====
// Ring store, end pointers, occupancy count and result registers of the deque.
// Depends on cbd_pkg; driven by commands from cbd_ctrl.
module cbd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cbd_pkg::cbd_cmd_type              cmd,
   input  logic [cbd_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [cbd_pkg::WORD_W-1:0] req_push_value,
   input  logic [cbd_pkg::CAP_W-1:0]         csr_data,
   output logic                              rsp_ok,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_pop_value,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_front_value,
   output logic signed [cbd_pkg::WORD_W-1:0] rsp_rear_value,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full
);

   localparam int IDX_W  = cbd_pkg::IDX_W;
   localparam int CNT_W  = cbd_pkg::CNT_W;
   localparam int WORD_W = cbd_pkg::WORD_W;

   function automatic logic [CNT_W-1:0] cap_clamp(input logic [cbd_pkg::CAP_W-1:0] v);
      int unsigned c;
      c = 32'(v);
      if (c < 1) c = 1;
      if (c > cbd_pkg::DEPTH) c = cbd_pkg::DEPTH;
      return CNT_W'(c);
   endfunction

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(i) + CNT_W'(1);
      return (n >= cap) ? '0 : IDX_W'(n);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] m;
      m = cap - CNT_W'(1);
      return (i == '0 || CNT_W'(i) >= cap) ? IDX_W'(m) : i - IDX_W'(1);
   endfunction

   logic [WORD_W-1:0]         ring_mem [cbd_pkg::DEPTH];
   logic [WORD_W-1:0]         rd_head_ff, rd_tail_ff;
   logic [IDX_W-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]          occ_ff, occ_in, cap_ff, cap_in;
   logic [cbd_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [WORD_W-1:0]         value_ff, value_in;
   logic                      ok_ff, ok_in;
   logic [WORD_W-1:0]         pop_ff, pop_in;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      cap_in   = cap_ff;
      func_in  = func_ff;
      value_in = value_ff;
      ok_in    = ok_ff;
      pop_in   = pop_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      if (cmd.load) begin
         func_in  = req_func;
         value_in = req_push_value;
      end
      if (cmd.clear) begin
         cap_in  = cap_clamp(csr_data);
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
      if (cmd.exec) begin
         ok_in  = 1'b0;
         pop_in = cbd_pkg::NEG_ONE;
         unique case (func_ff)
            cbd_pkg::FUNC_PUSH_FRONT, cbd_pkg::FUNC_PUSH_REAR: begin
               if (occ_ff < cap_ff) begin
                  wr_en = 1'b1;
                  if (occ_ff == '0) begin
                     head_in = '0;
                     tail_in = '0;
                     wr_addr = '0;
                  end else if (func_ff == cbd_pkg::FUNC_PUSH_FRONT) begin
                     head_in = ring_prev(head_ff, cap_ff);
                     wr_addr = head_in;
                  end else begin
                     tail_in = ring_next(tail_ff, cap_ff);
                     wr_addr = tail_in;
                  end
                  occ_in = occ_ff + CNT_W'(1);
                  ok_in  = 1'b1;
               end
            end
            cbd_pkg::FUNC_POP_FRONT, cbd_pkg::FUNC_POP_REAR: begin
               if (occ_ff != '0) begin
                  // The end entries were read while the request sat in idle.
                  if (func_ff == cbd_pkg::FUNC_POP_FRONT) begin
                     pop_in  = rd_head_ff;
                     head_in = ring_next(head_ff, cap_ff);
                  end else begin
                     pop_in  = rd_tail_ff;
                     tail_in = ring_prev(tail_ff, cap_ff);
                  end
                  occ_in = occ_ff - CNT_W'(1);
                  if (occ_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end
                  ok_in = 1'b1;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         cap_ff  <= cap_clamp(cbd_pkg::CAP_RESET);
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         cap_ff  <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      ok_ff    <= ok_in;
      pop_ff   <= pop_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= value_ff;
      rd_head_ff <= ring_mem[head_ff];
      rd_tail_ff <= ring_mem[tail_ff];
   end

   assign rsp_ok          = ok_ff;
   assign rsp_pop_value   = pop_ff;
   assign rsp_front_value = (occ_ff != '0) ? rd_head_ff : cbd_pkg::NEG_ONE;
   assign rsp_rear_value  = (occ_ff != '0) ? rd_tail_ff : cbd_pkg::NEG_ONE;
   assign rsp_is_empty    = (occ_ff == '0);
   assign rsp_is_full     = (occ_ff >= cap_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cap_ff)
      else $error("occupancy exceeds capacity");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == '0) && (tail_ff == '0))
      else $error("pointers not cleared on empty deque");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != '0) |-> (CNT_W'(head_ff) < cap_ff) && (CNT_W'(tail_ff) < cap_ff))
      else $error("end pointer outside the ring");

endmodule

// ===== tb/sv/tb_circular_buffer_deque.sv =====
// Self-checking testbench for circular_buffer_deque: push, pop and query requests
// plus capacity writes, with every result checked against an in-bench deque model.
// Depends on cbd_pkg and the circular_buffer_deque RTL; needs no other file.
module tb_circular_buffer_deque;
   timeunit 1ns;
   timeprecision 1ps;
   import cbd_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int MAX_PRINTS    = 40;

   localparam logic [FUNC_W-1:0] FUNC_LAST    = '1;
   localparam logic [CAP_W-1:0]  CAP_RAW_ZERO = '0;
   localparam logic [CAP_W-1:0]  CAP_RAW_MAX  = '1;

   typedef enum logic [1:0] {STIM_REQUEST, STIM_CAPACITY, STIM_DRAIN} stim_kind_type;

   typedef struct {
      stim_kind_type            kind;
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] word;
      logic [CAP_W-1:0]         cap;
   } stim_type;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] pop_value;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } deque_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [FUNC_W-1:0]        req_func = '0;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ok;
   logic signed [WORD_W-1:0] rsp_pop_value;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_rear_value;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_data = '0;

   // Shadow deque state.
   logic signed [WORD_W-1:0] dq_store [DEPTH];
   int                       dq_head = 0;
   int                       dq_tail = 0;
   int                       dq_count = 0;
   logic [CAP_W-1:0]         dq_cap = CAP_RESET;

   stim_type         pending_q [$];
   deque_result_type expected_q [$];

   int burst_left = 0;
   int gap_left = 0;
   int quiet_cycles = 0;
   int cycles = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int pushes_taken = 0;
   int pushes_refused = 0;
   int pops_taken = 0;
   int pops_empty = 0;
   int queries = 0;
   int full_results = 0;
   int cap_writes = 0;

   circular_buffer_deque u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   // Capacity values outside 1..DEPTH are clamped into that range.
   function automatic int usable_slots();
      if (dq_cap == 0) return 1;
      if (dq_cap > DEPTH) return DEPTH;
      return int'(dq_cap);
   endfunction

   function automatic int ring_succ(int i, int cap);
      return (i + 1 >= cap) ? 0 : i + 1;
   endfunction

   function automatic int ring_pred(int i, int cap);
      return (i == 0 || i >= cap) ? cap - 1 : i - 1;
   endfunction

   function automatic void set_capacity(logic [CAP_W-1:0] value);
      dq_cap = value;
      dq_head = 0;
      dq_tail = 0;
      dq_count = 0;
      cap_writes++;
   endfunction

   function automatic deque_result_type deque_step(logic [FUNC_W-1:0] func,
                                                   logic signed [WORD_W-1:0] word);
      deque_result_type r;
      int cap;
      cap = usable_slots();
      r.ok = 1'b0;
      r.pop_value = NEG_ONE;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (dq_count < cap) begin
               // The first word of an empty deque always lands in entry 0.
               if (dq_count == 0) begin
                  dq_head = 0;
                  dq_tail = 0;
                  dq_store[0] = word;
               end else if (func == FUNC_PUSH_FRONT) begin
                  dq_head = ring_pred(dq_head, cap);
                  dq_store[dq_head] = word;
               end else begin
                  dq_tail = ring_succ(dq_tail, cap);
                  dq_store[dq_tail] = word;
               end
               dq_count++;
               r.ok = 1'b1;
               pushes_taken++;
            end else begin
               pushes_refused++;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR: begin
            if (dq_count > 0) begin
               if (func == FUNC_POP_FRONT) begin
                  r.pop_value = dq_store[dq_head];
                  dq_head = ring_succ(dq_head, cap);
               end else begin
                  r.pop_value = dq_store[dq_tail];
                  dq_tail = ring_pred(dq_tail, cap);
               end
               dq_count--;
               if (dq_count == 0) begin
                  dq_head = 0;
                  dq_tail = 0;
               end
               r.ok = 1'b1;
               pops_taken++;
            end else begin
               pops_empty++;
            end
         end
         default: queries++;
      endcase
      r.front_value = (dq_count > 0) ? dq_store[dq_head] : NEG_ONE;
      r.rear_value  = (dq_count > 0) ? dq_store[dq_tail] : NEG_ONE;
      r.is_empty    = (dq_count == 0);
      r.is_full     = (dq_count >= cap);
      if (r.is_full) full_results++;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%08h, expected 0x%08h",
                                   results_seen, name, got, want));
   endtask

   function automatic void add_request(logic [FUNC_W-1:0] func, logic signed [WORD_W-1:0] word);
      stim_type s;
      s.kind = STIM_REQUEST;
      s.func = func;
      s.word = word;
      s.cap = '0;
      pending_q.push_back(s);
   endfunction

   function automatic void add_capacity(logic [CAP_W-1:0] cap);
      stim_type s;
      s.kind = STIM_CAPACITY;
      s.func = FUNC_QUERY;
      s.word = '0;
      s.cap = cap;
      pending_q.push_back(s);
   endfunction

   function automatic void add_drain();
      stim_type s;
      s.kind = STIM_DRAIN;
      s.func = FUNC_QUERY;
      s.word = '0;
      s.cap = '0;
      pending_q.push_back(s);
   endfunction

   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Driver: presents queued requests in bursts and writes the capacity only
   // once the deque has stayed quiet, with no result outstanding and nothing driven.
   always @(posedge clock) begin
      logic next_start;
      logic next_csr;
      stim_type item;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         quiet_cycles = 0;
      end else begin
         next_start = start;
         next_csr = csr_valid;
         if (start && !busy) begin
            expected_q.push_back(deque_step(req_func, req_push_value));
            requests_sent++;
            next_start = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         end
         if (csr_valid && csr_ready) begin
            set_capacity(csr_data);
            next_csr = 1'b0;
         end
         if (expected_q.size() == 0 && !start && !csr_valid) quiet_cycles++;
         else quiet_cycles = 0;
         if (!next_start && !next_csr && pending_q.size() > 0) begin
            item = pending_q[0];
            case (item.kind)
               STIM_REQUEST: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     if (burst_left == 0) burst_left = $urandom_range(1, 24);
                     req_func <= item.func;
                     req_push_value <= item.word;
                     next_start = 1'b1;
                     pending_q.delete(0);
                  end
               end
               STIM_CAPACITY: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     csr_data <= item.cap;
                     next_csr = 1'b1;
                     pending_q.delete(0);
                  end
               end
               default: begin
                  if (quiet_cycles >= SETTLE_CYCLES) pending_q.delete(0);
               end
            endcase
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                      results_seen));
         end else begin
            want = expected_q.pop_front();
            check_field("ok", WORD_W'(rsp_ok), WORD_W'(want.ok));
            check_field("pop_value", rsp_pop_value, want.pop_value);
            check_field("front_value", rsp_front_value, want.front_value);
            check_field("rear_value", rsp_rear_value, want.rear_value);
            check_field("is_empty", WORD_W'(rsp_is_empty), WORD_W'(want.is_empty));
            check_field("is_full", WORD_W'(rsp_is_full), WORD_W'(want.is_full));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d requests still expected",
                  cycles, expected_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int made;
      int len;
      int hi;
      int push_pct;

      // A query and underflow on the empty deque, then the extreme words.
      add_request(FUNC_QUERY, random_word());
      add_request(FUNC_POP_FRONT, random_word());
      add_request(FUNC_POP_REAR, random_word());
      add_request(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
      add_request(FUNC_PUSH_REAR, 32'sh8000_0000);
      add_request(FUNC_PUSH_FRONT, '0);
      add_request(FUNC_PUSH_REAR, '1);
      add_request(FUNC_PUSH_FRONT, 32'sh5555_5555);
      add_request(FUNC_PUSH_REAR, 32'shAAAA_AAAA);
      for (int f = int'(FUNC_QUERY) + 1; f <= int'(FUNC_LAST); f++)
         add_request(FUNC_W'(f), random_word());
      for (int k = 0; k < 3; k++) begin
         add_request(FUNC_POP_FRONT, random_word());
         add_request(FUNC_POP_REAR, random_word());
      end
      add_request(FUNC_POP_FRONT, random_word());
      add_drain();
      // Single-entry deque: the second push is refused.
      add_capacity(CAP_W'(1));
      add_request(FUNC_PUSH_REAR, 32'sh1234_5678);
      add_request(FUNC_PUSH_FRONT, random_word());
      add_request(FUNC_POP_REAR, random_word());
      add_request(FUNC_POP_REAR, random_word());
      // A capacity of zero behaves like one.
      add_capacity(CAP_RAW_ZERO);
      add_request(FUNC_PUSH_FRONT, random_word());
      add_request(FUNC_PUSH_REAR, random_word());
      add_capacity(CAP_RAW_MAX);

      // Random phases: each fills toward full, then drains toward empty.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       add_capacity(CAP_W'(1));
            1:       add_capacity(CAP_W'(DEPTH));
            2:       add_capacity(CAP_RAW_ZERO);
            3:       add_capacity(CAP_W'($urandom_range(DEPTH + 1, int'(CAP_RAW_MAX))));
            default: add_capacity(CAP_W'($urandom_range(2, DEPTH - 1)));
         endcase
         len = $urandom_range(30, 140);
         hi = $urandom_range(55, 90);
         for (int k = 0; k < len; k++) begin
            push_pct = (k < len / 2) ? hi : 100 - hi;
            if ($urandom_range(0, 19) == 0)
               add_request(FUNC_W'($urandom_range(int'(FUNC_QUERY), int'(FUNC_LAST))),
                           random_word());
            else if ($urandom_range(1, 100) <= push_pct)
               add_request($urandom_range(0, 1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT,
                           random_word());
            else
               add_request($urandom_range(0, 1) ? FUNC_POP_REAR : FUNC_POP_FRONT,
                           random_word());
            if (k == len / 2 && $urandom_range(0, 3) == 0) add_drain();
         end
         made += len;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge so the driver's updates have settled.
      while (pending_q.size() > 0 || start || csr_valid) @(negedge clock);
      while (expected_q.size() > 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);

      $display("Ran %0d requests over %0d capacity settings: %0d pushes, %0d refused",
               requests_sent, cap_writes, pushes_taken, pushes_refused);
      $display("  %0d pops, %0d on empty, %0d queries, %0d full results, %0d mismatches",
               pops_taken, pops_empty, queries, full_results, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== circular_buffer_deque.f =====
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_ctrl.sv
hw/rtl/cbd_datapath.sv
hw/rtl/circular_buffer_deque.sv
tb/sv/tb_circular_buffer_deque.sv
